[rtl/rle_pkg.sv]
// Shared types, codes and sizes of the Raft leader-election core.
package rle_pkg;

  localparam int MAX_NODES = 16;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);
  localparam int Q_CW = $clog2(Q_DEPTH + 1);
  localparam int RES_DEPTH = 2;
  localparam int RES_AW = $clog2(RES_DEPTH);
  localparam int RES_CW = $clog2(RES_DEPTH + 1);

  localparam logic [4:0] VOTE_NONE = 5'd16;
  localparam logic [4:0] DEST_ALL = 5'd16;
  localparam logic [4:0] MAX_NODES_W = 5'(MAX_NODES);
  localparam logic [4:0] VOTES_MAX = 5'd31;
  localparam logic [15:0] TICKS_MAX = 16'hFFFF;
  localparam logic [31:0] TERM_MAX = 32'hFFFF_FFFF;

  localparam logic [4:0] CFG_NODE_COUNT_RST = 5'd1;
  localparam logic [15:0] CFG_TIMEOUT_RST = 16'd300;
  localparam logic [15:0] CFG_INTERVAL_RST = 16'd100;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_VOTE_REQ = 2'd1,
    CMD_VOTE_REPLY = 2'd2,
    CMD_HEARTBEAT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ROLE_FOLLOWER = 2'd0,
    ROLE_CANDIDATE = 2'd1,
    ROLE_LEADER = 2'd2
  } role_t;

  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_VOTE_REPLY = 3'd1,
    KIND_HB_ACK = 3'd2,
    KIND_VOTE_REQ_ALL = 3'd3,
    KIND_HEARTBEAT_ALL = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    REG_NODE_ID = 2'd0,
    REG_NODE_COUNT = 2'd1,
    REG_TIMEOUT = 2'd2,
    REG_INTERVAL = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    cmd_t cmd;
    logic [31:0] msg_term;
    logic [3:0] sender_id;
    logic granted;
  } item_t;

  typedef struct packed {
    logic valid;
    item_t item;
  } intake_t;

  typedef struct packed {
    kind_t kind;
    logic [31:0] term;
    logic [4:0] dest;
    logic granted;
    role_t role;
    logic [3:0] leader;
  } result_t;

endpackage

[rtl/raft_leader_election_core.sv]
// Top level of the Raft leader-election core: intake queue plus election engine.
//
// Input channel: present command, msg_term, sender_id and granted_in with push;
// a request is taken on a clock edge where push is high and full is low.
// Commands are tick, vote request, vote reply and heartbeat.
// Result channel: while empty is low the oldest result sits on send_kind,
// send_term, send_dest, send_granted, role_now, known_leader and term_now;
// it is consumed on an edge where pop is high. Every request yields one result.
// Configuration: cfg_valid/cfg_ready with cfg_index selecting node id, node
// count, election timeout or heartbeat interval; cfg_ready is always high.
// Write configuration only while no request is in flight. Writing the node id
// restarts the election state under that id.
// A result passes through the intake queue and then the result queue before it
// is on the output ports. One request per cycle is sustained while the result
// queue has room or is popped: the engine resolves a whole event combinationally
// and a two-entry result queue holds its results while pop is low.
// When the receiver stalls, the result queue and then the four-entry intake
// queue fill, after which full stays high until results are popped.
// Reset (rst, synchronous) empties both queues, loads default configuration and
// starts node 0 as leader of term 1.
module raft_leader_election_core import rle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  command,
  input  logic [31:0] msg_term,
  input  logic [3:0]  sender_id,
  input  logic        granted_in,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  send_kind,
  output logic [31:0] send_term,
  output logic [4:0]  send_dest,
  output logic        send_granted,
  output logic [1:0]  role_now,
  output logic [3:0]  known_leader,
  output logic [31:0] term_now,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  intake_t head;
  logic    take;
  result_t res;

  rle_intake u_intake (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .command    (command),
    .msg_term   (msg_term),
    .sender_id  (sender_id),
    .granted_in (granted_in),
    .head       (head),
    .take       (take)
  );

  rle_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .take      (take),
    .pop       (pop),
    .empty     (empty),
    .res       (res)
  );

  assign send_kind = res.kind;
  assign send_term = res.term;
  assign send_dest = res.dest;
  assign send_granted = res.granted;
  assign role_now = res.role;
  assign known_leader = res.leader;
  assign term_now = res.term;

endmodule

[rtl/rle_intake.sv]
// Front end: accepts requests, decodes the command and queues them for the engine.
module rle_intake import rle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  command,
  input  logic [31:0] msg_term,
  input  logic [3:0]  sender_id,
  input  logic        granted_in,
  output intake_t     head,
  input  logic        take
);

  item_t q [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;
  logic push_ok;
  logic pop_ok;

  assign full = (count == Q_CW'(Q_DEPTH));
  assign push_ok = push && !full;
  assign pop_ok = take && head.valid;

  assign head.valid = (count != '0);
  assign head.item = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q[wr_ptr].cmd <= cmd_t'(command);
      q[wr_ptr].msg_term <= msg_term;
      q[wr_ptr].sender_id <= sender_id;
      q[wr_ptr].granted <= granted_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push_ok) wr_ptr <= wr_ptr + 1'b1;
      if (pop_ok) rd_ptr <= rd_ptr + 1'b1;
      case ({push_ok, pop_ok})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= Q_CW'(Q_DEPTH))
    else $error("intake queue count beyond depth");
  assert property (@(posedge clk) disable iff (rst)
    !push_ok && !pop_ok |=> count == $past(count))
    else $error("intake queue count moved without a request");
  assert property (@(posedge clk) disable iff (rst)
    head.valid |-> (wr_ptr - rd_ptr) == count[Q_AW-1:0] || full)
    else $error("intake queue pointers disagree with count");

endmodule

[rtl/rle_engine.sv]
// Back end: election state, configuration registers and the result queue.
module rle_engine import rle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  intake_t     head,
  output logic        take,
  input  logic        pop,
  output logic        empty,
  output result_t     res
);

  // Configuration registers.
  logic [3:0]  node_id;
  logic [4:0]  node_count;
  logic [15:0] election_timeout;
  logic [15:0] heartbeat_interval;

  // Election state.
  role_t       role;
  logic [31:0] cur_term;
  logic [4:0]  vote_given;
  logic [4:0]  votes_count;
  logic [3:0]  leader_known;
  logic [15:0] idle_ticks;
  logic [15:0] beat_ticks;

  role_t       role_next;
  logic [31:0] cur_term_next;
  logic [4:0]  vote_given_next;
  logic [4:0]  votes_count_next;
  logic [3:0]  leader_known_next;
  logic [15:0] idle_ticks_next;
  logic [15:0] beat_ticks_next;
  result_t     step_res;

  result_t res_q [RES_DEPTH];
  logic [RES_AW-1:0] res_wr;
  logic [RES_AW-1:0] res_rd;
  logic [RES_CW-1:0] res_count;
  logic res_pop;
  logic id_we;
  logic [4:0] half;

  assign cfg_ready = 1'b1;
  assign id_we = cfg_valid && (cfg_index == REG_NODE_ID);

  assign empty = (res_count == '0);
  assign res_pop = pop && !empty;
  assign take = head.valid && ((res_count != RES_CW'(RES_DEPTH)) || res_pop);
  assign res = res_q[res_rd];

  // A majority is strictly more than half of the cluster size, clamped.
  assign half = ((node_count > MAX_NODES_W) ? MAX_NODES_W : node_count) >> 1;

  always_comb begin
    logic [15:0] tick_inc;
    logic [31:0] mterm;
    logic [4:0]  vote_inc;
    kind_t       kind;
    logic [4:0]  dest;
    logic        grant;

    role_next = role;
    cur_term_next = cur_term;
    vote_given_next = vote_given;
    votes_count_next = votes_count;
    leader_known_next = leader_known;
    idle_ticks_next = idle_ticks;
    beat_ticks_next = beat_ticks;
    kind = KIND_NONE;
    dest = 5'd0;
    grant = 1'b0;
    mterm = head.item.msg_term;
    tick_inc = '0;
    vote_inc = '0;

    case (head.item.cmd)
      CMD_TICK: begin
        if (role == ROLE_LEADER) begin
          tick_inc = (beat_ticks < TICKS_MAX) ? beat_ticks + 16'd1 : beat_ticks;
          beat_ticks_next = tick_inc;
          if (tick_inc >= heartbeat_interval) begin
            beat_ticks_next = '0;
            kind = KIND_HEARTBEAT_ALL;
            dest = DEST_ALL;
          end
        end else begin
          tick_inc = (idle_ticks < TICKS_MAX) ? idle_ticks + 16'd1 : idle_ticks;
          idle_ticks_next = tick_inc;
          if (tick_inc >= election_timeout) begin
            role_next = ROLE_CANDIDATE;
            cur_term_next = (cur_term != TERM_MAX) ? cur_term + 32'd1 : cur_term;
            vote_given_next = {1'b0, node_id};
            votes_count_next = 5'd1;
            idle_ticks_next = '0;
            dest = DEST_ALL;
            kind = KIND_VOTE_REQ_ALL;
            // A single-node cluster wins with its own vote.
            if (5'd1 > half) begin
              role_next = ROLE_LEADER;
              leader_known_next = node_id;
              beat_ticks_next = '0;
              kind = KIND_HEARTBEAT_ALL;
            end
          end
        end
      end
      CMD_VOTE_REQ: begin
        if (mterm > cur_term) begin
          cur_term_next = mterm;
          role_next = ROLE_FOLLOWER;
          vote_given_next = VOTE_NONE;
        end
        if (mterm == cur_term_next && (vote_given_next == VOTE_NONE ||
            vote_given_next == {1'b0, head.item.sender_id})) begin
          grant = 1'b1;
          vote_given_next = {1'b0, head.item.sender_id};
          idle_ticks_next = '0;
        end
        kind = KIND_VOTE_REPLY;
        dest = {1'b0, head.item.sender_id};
      end
      CMD_VOTE_REPLY: begin
        if (role == ROLE_CANDIDATE) begin
          if (mterm > cur_term) begin
            cur_term_next = mterm;
            role_next = ROLE_FOLLOWER;
            vote_given_next = VOTE_NONE;
          end else if (mterm == cur_term && head.item.granted) begin
            vote_inc = (votes_count < VOTES_MAX) ? votes_count + 5'd1 : votes_count;
            votes_count_next = vote_inc;
            if (vote_inc > half) begin
              role_next = ROLE_LEADER;
              leader_known_next = node_id;
              beat_ticks_next = '0;
              kind = KIND_HEARTBEAT_ALL;
              dest = DEST_ALL;
            end
          end
        end
      end
      CMD_HEARTBEAT: begin
        if (mterm >= cur_term) begin
          cur_term_next = mterm;
          role_next = ROLE_FOLLOWER;
          leader_known_next = head.item.sender_id;
          idle_ticks_next = '0;
          vote_given_next = VOTE_NONE;
        end
        kind = KIND_HB_ACK;
        dest = {1'b0, head.item.sender_id};
      end
      default: begin
        kind = KIND_NONE;
      end
    endcase

    step_res.kind = kind;
    step_res.term = cur_term_next;
    step_res.dest = dest;
    step_res.granted = grant;
    step_res.role = role_next;
    step_res.leader = leader_known_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_id <= '0;
      node_count <= CFG_NODE_COUNT_RST;
      election_timeout <= CFG_TIMEOUT_RST;
      heartbeat_interval <= CFG_INTERVAL_RST;
      role <= ROLE_LEADER;
      cur_term <= 32'd1;
      vote_given <= 5'd0;
      votes_count <= '0;
      leader_known <= '0;
      idle_ticks <= '0;
      beat_ticks <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          REG_NODE_ID: node_id <= cfg_data[3:0];
          REG_NODE_COUNT: node_count <= cfg_data[4:0];
          REG_TIMEOUT: election_timeout <= cfg_data;
          REG_INTERVAL: heartbeat_interval <= cfg_data;
          default: node_count <= node_count;
        endcase
      end
      // A new node id restarts the node as at power-up under that id.
      if (id_we) begin
        role <= (cfg_data[3:0] == 4'd0) ? ROLE_LEADER : ROLE_FOLLOWER;
        cur_term <= 32'd1;
        vote_given <= (cfg_data[3:0] == 4'd0) ? 5'd0 : VOTE_NONE;
        votes_count <= '0;
        leader_known <= '0;
        idle_ticks <= '0;
        beat_ticks <= '0;
      end else if (take) begin
        role <= role_next;
        cur_term <= cur_term_next;
        vote_given <= vote_given_next;
        votes_count <= votes_count_next;
        leader_known <= leader_known_next;
        idle_ticks <= idle_ticks_next;
        beat_ticks <= beat_ticks_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) res_q[res_wr] <= step_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr <= '0;
      res_rd <= '0;
      res_count <= '0;
    end else begin
      if (take) res_wr <= res_wr + 1'b1;
      if (res_pop) res_rd <= res_rd + 1'b1;
      case ({take, res_pop})
        2'b10: res_count <= res_count + 1'b1;
        2'b01: res_count <= res_count - 1'b1;
        default: res_count <= res_count;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) res_count <= RES_CW'(RES_DEPTH))
    else $error("result queue count beyond depth");
  assert property (@(posedge clk) disable iff (rst) vote_given <= VOTE_NONE)
    else $error("vote holder out of range");
  assert property (@(posedge clk) disable iff (rst)
    !id_we |=> cur_term >= $past(cur_term))
    else $error("term decreased without a node id write");
  assert property (@(posedge clk) disable iff (rst)
    take && !id_we && head.item.cmd == CMD_HEARTBEAT && head.item.msg_term >= cur_term
    |=> role == ROLE_FOLLOWER && leader_known == $past(head.item.sender_id))
    else $error("current heartbeat did not make the node a follower");

endmodule
